// ===== hw/rtl/nlse_pkg.sv =====
package nlse_pkg;

    // default geometry of one automaton layer
    localparam int STATE_COUNT_DEF = 8;
    localparam int SYMBOL_MAX_DEF  = 8;

    // widest layout the transaction fields can name
    localparam int ROW_SYMBOLS = 8;

    // field widths of the channels
    localparam int MODE_W    = 3;
    localparam int INDEX_W   = 3;
    localparam int MASK_W    = 8;
    localparam int SYMCNT_W  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_INIT   = 3'd2,
        MODE_FINAL  = 3'd3,
        MODE_EXPAND = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_EXPAND
    } state_t;

endpackage

// ===== hw/rtl/nlse_if.sv =====
interface nlse_item_if;
    import nlse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   left_index;
    logic [INDEX_W-1:0]   symbol_index;
    logic [INDEX_W-1:0]   right_index;
    logic [MASK_W-1:0]    subset_mask;

    modport source (
        output valid, mode, left_index, symbol_index, right_index, subset_mask,
        input  ready
    );

    modport sink (
        input  valid, mode, left_index, symbol_index, right_index, subset_mask,
        output ready
    );
endinterface

interface nlse_result_if;
    import nlse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   out_symbol;
    logic [MASK_W-1:0]    next_mask;
    logic                 next_nonempty;
    logic                 is_initial;
    logic                 is_final;
    logic                 last;

    modport source (
        output valid, out_symbol, next_mask, next_nonempty, is_initial, is_final, last,
        input  ready
    );

    modport sink (
        input  valid, out_symbol, next_mask, next_nonempty, is_initial, is_final, last,
        output ready
    );
endinterface

// ===== hw/rtl/nfa_layer_subset_expander_unit.sv =====
// load: clear, init and final act at accept; add reads at accept, writes back in ST_ADD_WR
// expand: each symbol word read in ST_EXPAND waits in the pending register, then moves to
// the output register; one result per cycle unless result.ready stalls; the single read
// port of the transition memory (one symbol word per read) sets the rate
// reset: asynchronous, active low; transition store empty, marks zero, symbol_count 8,
// no result pending
module nfa_layer_subset_expander_unit #(
    parameter int STATE_COUNT = nlse_pkg::STATE_COUNT_DEF,
    parameter int SYMBOL_MAX  = nlse_pkg::SYMBOL_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    nlse_item_if.sink                     item,
    nlse_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [nlse_pkg::SYMCNT_W-1:0] cfg_wdata
);
    import nlse_pkg::*;

    // memory holds one word per symbol; word bit (left * STATE_COUNT + right)
    localparam int SYM_DEPTH = (SYMBOL_MAX < ROW_SYMBOLS) ? SYMBOL_MAX : ROW_SYMBOLS;
    localparam int SYM_AW    = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
    localparam int SC_AW     = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int WORD_W    = STATE_COUNT * STATE_COUNT;
    localparam int BIT_AW    = (WORD_W > 1) ? $clog2(WORD_W) : 1;

    // control
    state_t                 state_reg, state_next;
    logic [SYMCNT_W-1:0]    symbol_count_reg;
    logic [SYMCNT_W-1:0]    n_eff;
    logic                   accept;
    logic                   add_ok;

    // transition memory with per-entry valid bits (clear resets all of those at accept)
    logic [WORD_W-1:0]      rel_mem [SYM_DEPTH];
    logic [SYM_DEPTH-1:0]   entry_vld_reg;
    logic                   rd_en;
    logic [SYM_AW-1:0]      rd_addr;
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_vld_reg;
    logic [WORD_W-1:0]      word_eff;
    logic [WORD_W-1:0]      wr_word;
    logic [BIT_AW-1:0]      wr_bit;

    // pending add transaction
    logic [SYM_AW-1:0]      add_addr_reg;
    logic [SC_AW-1:0]       add_left_reg;
    logic [SC_AW-1:0]       add_right_reg;

    // marks and the subset under expansion
    logic [STATE_COUNT-1:0] initial_reg;
    logic [STATE_COUNT-1:0] final_reg;
    logic [STATE_COUNT-1:0] subset_reg;
    logic                   init_flag_reg;
    logic                   fin_flag_reg;
    logic [STATE_COUNT-1:0] subset_in;

    // expand read pipeline: issue counter, then read data waiting for the output slot
    logic [SYMCNT_W-1:0]    issue_cnt_reg;
    logic                   pend_reg;
    logic [INDEX_W-1:0]     pend_sym_reg;
    logic                   issue;
    logic                   load_out;
    logic                   last_c;
    logic [STATE_COUNT-1:0] next_c;

    // output register
    logic                   out_valid_reg;
    logic [INDEX_W-1:0]     out_symbol_reg;
    logic [MASK_W-1:0]      next_mask_reg;
    logic                   next_nonempty_reg;
    logic                   is_initial_reg;
    logic                   is_final_reg;
    logic                   last_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    // symbol count: zero counts as one, saturate at the memory depth
    always_comb
    begin
        if (symbol_count_reg == '0)
        begin
            n_eff = SYMCNT_W'(1);
        end
        else if (symbol_count_reg > SYMCNT_W'(SYM_DEPTH))
        begin
            n_eff = SYMCNT_W'(SYM_DEPTH);
        end
        else
        begin
            n_eff = symbol_count_reg;
        end
    end

    assign add_ok = ({1'b0, item.left_index} < 4'(STATE_COUNT)) &&
                    ({1'b0, item.right_index} < 4'(STATE_COUNT)) &&
                    ({1'b0, item.symbol_index} < 4'(SYM_DEPTH));

    assign subset_in = item.subset_mask[STATE_COUNT-1:0];

    // expand issue / drain
    assign load_out = pend_reg && (!out_valid_reg || result.ready);
    assign issue    = (state_reg == ST_EXPAND) && (issue_cnt_reg < n_eff) &&
                      (!pend_reg || load_out);
    assign last_c   = ((4'(pend_sym_reg) + 4'd1) == n_eff);

    assign word_eff = rd_vld_reg ? rd_word_reg : '0;

    // union of the rows of every subset member
    always_comb
    begin
        next_c = '0;
        for (int l = 0; l < STATE_COUNT; l++)
        begin
            if (subset_reg[l])
            begin
                next_c = next_c | word_eff[l*STATE_COUNT +: STATE_COUNT];
            end
        end
    end

    // read-modify-write data for add
    always_comb
    begin
        wr_bit  = BIT_AW'(add_left_reg) * BIT_AW'(STATE_COUNT) + BIT_AW'(add_right_reg);
        wr_word = word_eff | (WORD_W'(1) << wr_bit);
    end

    // read port: add reads its symbol word at accept, expand walks the symbols
    always_comb
    begin
        rd_en   = issue || (accept && (item.mode == MODE_ADD) && add_ok);
        rd_addr = (state_reg == ST_EXPAND) ? issue_cnt_reg[SYM_AW-1:0]
                                           : item.symbol_index[SYM_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= rel_mem[rd_addr];
        end
        if (state_reg == ST_ADD_WR)
        begin
            rel_mem[add_addr_reg] <= wr_word;
        end
    end

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == MODE_ADD && add_ok)
                    begin
                        state_next = ST_ADD_WR;
                    end
                    else if (item.mode == MODE_EXPAND)
                    begin
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_ADD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_EXPAND:
            begin
                if (load_out && last_c)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state: config, valid bits, marks, expand pipeline, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= SYMCNT_W'(ROW_SYMBOLS);
            entry_vld_reg    <= '0;
            initial_reg      <= '0;
            final_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            issue_cnt_reg    <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                symbol_count_reg <= cfg_wdata;
            end

            if (rd_en)
            begin
                rd_vld_reg <= entry_vld_reg[rd_addr];
            end

            if (state_reg == ST_ADD_WR)
            begin
                entry_vld_reg[add_addr_reg] <= 1'b1;
            end

            if (accept)
            begin
                case (item.mode)
                    MODE_CLEAR:
                    begin
                        entry_vld_reg <= '0;
                        initial_reg   <= '0;
                        final_reg     <= '0;
                    end
                    MODE_INIT:
                    begin
                        if ({1'b0, item.left_index} < 4'(STATE_COUNT))
                        begin
                            initial_reg[item.left_index[SC_AW-1:0]] <= 1'b1;
                        end
                    end
                    MODE_FINAL:
                    begin
                        if ({1'b0, item.right_index} < 4'(STATE_COUNT))
                        begin
                            final_reg[item.right_index[SC_AW-1:0]] <= 1'b1;
                        end
                    end
                    MODE_EXPAND:
                    begin
                        issue_cnt_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + SYMCNT_W'(1);
                pend_reg      <= 1'b1;
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            add_addr_reg  <= item.symbol_index[SYM_AW-1:0];
            add_left_reg  <= item.left_index[SC_AW-1:0];
            add_right_reg <= item.right_index[SC_AW-1:0];
            if (item.mode == MODE_EXPAND)
            begin
                subset_reg    <= subset_in;
                init_flag_reg <= (subset_in != '0) && ((subset_in & ~initial_reg) == '0);
                fin_flag_reg  <= ((subset_in & final_reg) != '0);
            end
        end

        if (issue)
        begin
            pend_sym_reg <= issue_cnt_reg[INDEX_W-1:0];
        end

        if (load_out)
        begin
            out_symbol_reg    <= pend_sym_reg;
            next_mask_reg     <= MASK_W'(next_c);
            next_nonempty_reg <= (next_c != '0);
            is_initial_reg    <= init_flag_reg;
            is_final_reg      <= fin_flag_reg;
            last_reg          <= last_c;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_symbol    = out_symbol_reg;
    assign result.next_mask     = next_mask_reg;
    assign result.next_nonempty = next_nonempty_reg;
    assign result.is_initial    = is_initial_reg;
    assign result.is_final      = is_final_reg;
    assign result.last          = last_reg;

endmodule

// ===== hw/rtl/nlse_checker.sv =====
module nlse_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [nlse_pkg::INDEX_W-1:0] result_symbol,
    input logic [nlse_pkg::MASK_W-1:0]  result_next_mask,
    input logic                         result_next_nonempty,
    input logic                         result_last
);
    import nlse_pkg::*;

    logic [INDEX_W-1:0] exp_sym_reg;

    // symbol expected on the next result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sym_reg <= '0;
        end
        else if (result_valid && result_ready)
        begin
            exp_sym_reg <= result_last ? '0 : (result_symbol + INDEX_W'(1));
        end
    end

    // results of one expansion come in symbol order starting at zero
    a_symbol_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_symbol == exp_sym_reg))
        else $error("result symbol out of order");

    // nonempty flag agrees with the mask
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_next_nonempty == (result_next_mask != '0)))
        else $error("next_nonempty disagrees with next_mask");

    // no new item is taken while an expansion still owes results
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_last) |-> !item_ready)
        else $error("item accepted in the middle of an expansion");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(result_symbol) && $stable(result_next_mask)
             && $stable(result_last)))
        else $error("stalled result changed");

endmodule

bind nfa_layer_subset_expander_unit nlse_checker u_nlse_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_ready           (item.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_symbol        (result.out_symbol),
    .result_next_mask     (result.next_mask),
    .result_next_nonempty (result.next_nonempty),
    .result_last          (result.last)
);
